>>> src/rcbp_pkg.sv
// Shared definitions for the reference-counted buffer pool.
// Holds default parameters, request and status codes, field widths and the
// controller/datapath handshake structs. No dependencies.
package rcbp_pkg;

    localparam int DEF_BUFFER_COUNT = 256;
    localparam int DEF_BUFFER_BYTES = 65536;
    localparam int DEF_CACHE_DEPTH  = 4;

    // Request field widths
    localparam int ACTION_W = 3;
    localparam int ID_W     = 16;
    localparam int LEN_W    = 24;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int REF_W    = 8;
    localparam int USED_W   = 17;
    localparam int STAT_W   = 32;
    localparam int NUM_STAT = 5;

    // Per-buffer metadata word: {alloc, refs, used_bytes}
    localparam int META_W = 1 + REF_W + USED_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 208;

    localparam logic [REF_W-1:0]  REF_MAX = '1;
    localparam logic [STAT_W-1:0] CNT_MAX = '1;

    // Request codes; the unused codes act as query
    localparam logic [ACTION_W-1:0] ACT_ACQUIRE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD_REF    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_USED   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET_USED = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    // Statistics counter slots
    localparam int STAT_ACQ  = 0;
    localparam int STAT_REL  = 1;
    localparam int STAT_HIT  = 2;
    localparam int STAT_MISS = 3;
    localparam int STAT_EXH  = 4;

    typedef struct packed {
        logic clear;   // init sweep cycle
        logic start;   // request accepted, launch reads
        logic commit;  // apply updates and load the result
    } cmd_t;

    typedef struct packed {
        logic clear_last;  // sweep at its final entry
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

>>> src/rcbp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/rcbp_ctrl.sv
// Sequencer for the buffer pool: init sweep, request accept, commit.
// Depends on rcbp_pkg.
module rcbp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output rcbp_pkg::cmd_t cmd,
    input  rcbp_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.start  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.commit = (state_reg == S_EXEC) && sts.out_free;

endmodule

>>> src/rcbp_datapath.sv
// Datapath of the buffer pool: metadata and free-stack RAMs, recent-id cache,
// depth pointers, statistics and the result register. Depends on rcbp_pkg, rcbp_ram.
module rcbp_datapath #(
    parameter int BUFFER_COUNT = rcbp_pkg::DEF_BUFFER_COUNT,
    parameter int BUFFER_BYTES = rcbp_pkg::DEF_BUFFER_BYTES,
    parameter int CACHE_DEPTH  = rcbp_pkg::DEF_CACHE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rcbp_pkg::cmd_t                 cmd,
    output rcbp_pkg::sts_t                 sts,
    input  logic [rcbp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rcbp_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rcbp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [rcbp_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDW = $clog2(BUFFER_COUNT);
    localparam int FDW = $clog2(BUFFER_COUNT + 1);
    localparam int CDW = $clog2(CACHE_DEPTH + 1);
    localparam int CIW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int AW  = rcbp_pkg::ACTION_W;
    localparam int IW  = rcbp_pkg::ID_W;
    localparam int LW  = rcbp_pkg::LEN_W;
    localparam int RW  = rcbp_pkg::REF_W;
    localparam int UW  = rcbp_pkg::USED_W;
    localparam int SW  = rcbp_pkg::STAT_W;
    localparam int NS  = rcbp_pkg::NUM_STAT;
    localparam int PAD_W = rcbp_pkg::M_TDATA_W - (IW + 1 + RW + UW + NS * SW);

    localparam logic [IW:0]    COUNT_X   = (IW + 1)'(BUFFER_COUNT);
    localparam logic [FDW-1:0] COUNT_F   = FDW'(BUFFER_COUNT);
    localparam logic [CDW-1:0] CACHE_C   = CDW'(CACHE_DEPTH);
    localparam logic [LW-1:0]  BYTES_L   = LW'(BUFFER_BYTES);
    localparam logic [IDW-1:0] LAST_ID   = IDW'(BUFFER_COUNT - 1);

    // Request fields
    logic [IW-1:0] s_buf_idx;
    logic [LW-1:0] s_used_len;
    assign s_buf_idx  = s_tdata[IW-1:0];
    assign s_used_len = s_tdata[IW+LW-1:IW];

    logic [AW-1:0]  req_action_reg;
    logic [IW-1:0]  req_id_reg;
    logic [LW-1:0]  req_len_reg;
    logic [FDW-1:0] fdepth_reg, fdepth_next;
    logic [CDW-1:0] rdepth_reg, rdepth_next;
    logic [IDW-1:0] cache_reg [CACHE_DEPTH];
    logic [SW-1:0]  stat_reg [NS];
    logic [IDW-1:0] clr_idx_reg;

    logic                         out_valid_reg;
    logic [rcbp_pkg::STATUS_W-1:0] out_status_reg;
    logic [IW-1:0]                out_id_reg;
    logic                         out_inuse_reg;
    logic [RW-1:0]                out_ref_reg;
    logic [UW-1:0]                out_used_reg;

    // RAM ports
    logic                            meta_we_r;
    logic [IDW-1:0]                  meta_waddr_r;
    logic [rcbp_pkg::META_W-1:0]     meta_wdata_r;
    logic [rcbp_pkg::META_W-1:0]     meta_rdata;
    logic                            stack_we_r;
    logic [IDW-1:0]                  stack_waddr_r;
    logic [IDW-1:0]                  stack_wdata_r;
    logic [IDW-1:0]                  stack_rdata;
    logic [FDW-1:0]                  fdepth_m1;
    logic [CDW-1:0]                  rdepth_m1;

    // Commit-time decisions
    logic                         meta_we;
    logic [IDW-1:0]               meta_waddr;
    logic [rcbp_pkg::META_W-1:0]  meta_wdata;
    logic                         stack_we;
    logic                         cache_we;
    logic [NS-1:0]                bump;
    logic [rcbp_pkg::STATUS_W-1:0] res_status;
    logic [IW-1:0]                res_id;
    logic                         res_inuse;
    logic [RW-1:0]                res_ref;
    logic [UW-1:0]                res_used;
    logic                         rd_alloc;
    logic [RW-1:0]                rd_ref;
    logic [UW-1:0]                rd_used;
    logic [RW-1:0]                new_ref;
    logic [LW-1:0]                clamp_len;
    logic                         id_ok;
    logic                         got;
    logic [IDW-1:0]               pick;

    assign fdepth_m1 = fdepth_reg - 1'b1;
    assign rdepth_m1 = rdepth_reg - 1'b1;
    assign {rd_alloc, rd_ref, rd_used} = meta_rdata;
    assign id_ok     = {1'b0, req_id_reg} < COUNT_X;
    assign new_ref   = (rd_ref != '0) ? rd_ref - 1'b1 : '0;
    assign clamp_len = (req_len_reg > BYTES_L) ? BYTES_L : req_len_reg;

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = req_id_reg[IDW-1:0];
        meta_wdata = meta_rdata;
        stack_we   = 1'b0;
        cache_we   = 1'b0;
        fdepth_next = fdepth_reg;
        rdepth_next = rdepth_reg;
        bump       = '0;
        got        = 1'b0;
        pick       = stack_rdata;
        res_status = rcbp_pkg::ST_OK;
        res_id     = req_id_reg;
        res_inuse  = rd_alloc;
        res_ref    = rd_ref;
        res_used   = rd_used;

        if (req_action_reg == rcbp_pkg::ACT_ACQUIRE) begin
            // Cache first, then the free stack
            if (rdepth_reg != '0) begin
                pick        = cache_reg[rdepth_m1[CIW-1:0]];
                got         = 1'b1;
                rdepth_next = rdepth_m1;
                bump[rcbp_pkg::STAT_HIT] = 1'b1;
            end else begin
                bump[rcbp_pkg::STAT_MISS] = 1'b1;
                if (fdepth_reg != '0) begin
                    got         = 1'b1;
                    fdepth_next = fdepth_m1;
                end
            end
            if (got) begin
                meta_we    = 1'b1;
                meta_waddr = pick;
                meta_wdata = {1'b1, RW'(1), UW'(0)};
                bump[rcbp_pkg::STAT_ACQ] = 1'b1;
                res_id     = IW'(pick);
                res_inuse  = 1'b1;
                res_ref    = RW'(1);
                res_used   = '0;
            end else begin
                bump[rcbp_pkg::STAT_EXH] = 1'b1;
                res_status = rcbp_pkg::ST_EXHAUSTED;
                res_id     = '0;
                res_inuse  = 1'b0;
                res_ref    = '0;
                res_used   = '0;
            end
        end else if (!id_ok) begin
            res_status = rcbp_pkg::ST_BAD_ID;
            res_inuse  = 1'b0;
            res_ref    = '0;
            res_used   = '0;
        end else begin
            unique case (req_action_reg)
                rcbp_pkg::ACT_RELEASE: begin
                    if (rd_alloc) begin
                        meta_we    = 1'b1;
                        meta_wdata = {1'b1, new_ref, rd_used};
                        if (new_ref == '0) begin
                            meta_wdata = {1'b0, new_ref, UW'(0)};
                            bump[rcbp_pkg::STAT_REL] = 1'b1;
                            if (rdepth_reg < CACHE_C) begin
                                cache_we    = 1'b1;
                                rdepth_next = rdepth_reg + 1'b1;
                            end else if (fdepth_reg < COUNT_F) begin
                                stack_we    = 1'b1;
                                fdepth_next = fdepth_reg + 1'b1;
                            end
                        end
                    end
                end
                rcbp_pkg::ACT_ADD_REF: begin
                    meta_we = 1'b1;
                    if (rd_ref != rcbp_pkg::REF_MAX) begin
                        meta_wdata = {rd_alloc, rd_ref + 1'b1, rd_used};
                    end
                end
                rcbp_pkg::ACT_SET_USED: begin
                    meta_we    = 1'b1;
                    meta_wdata = {rd_alloc, rd_ref, clamp_len[UW-1:0]};
                end
                rcbp_pkg::ACT_RESET_USED: begin
                    meta_we    = 1'b1;
                    meta_wdata = {rd_alloc, rd_ref, UW'(0)};
                end
                default: begin
                end
            endcase
            {res_inuse, res_ref, res_used} = meta_wdata;
        end
    end

    // Init sweep overrides the request write ports
    always_comb begin
        if (cmd.clear) begin
            meta_we_r     = 1'b1;
            meta_waddr_r  = clr_idx_reg;
            meta_wdata_r  = '0;
            stack_we_r    = 1'b1;
            stack_waddr_r = clr_idx_reg;
            stack_wdata_r = LAST_ID - clr_idx_reg;
        end else begin
            meta_we_r     = cmd.commit && meta_we;
            meta_waddr_r  = meta_waddr;
            meta_wdata_r  = meta_wdata;
            stack_we_r    = cmd.commit && stack_we;
            stack_waddr_r = fdepth_reg[IDW-1:0];
            stack_wdata_r = req_id_reg[IDW-1:0];
        end
    end

    rcbp_ram #(
        .WIDTH (rcbp_pkg::META_W),
        .DEPTH (BUFFER_COUNT)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we_r),
        .waddr (meta_waddr_r),
        .wdata (meta_wdata_r),
        .re    (cmd.start),
        .raddr (s_buf_idx[IDW-1:0]),
        .rdata (meta_rdata)
    );

    rcbp_ram #(
        .WIDTH (IDW),
        .DEPTH (BUFFER_COUNT)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we_r),
        .waddr (stack_waddr_r),
        .wdata (stack_wdata_r),
        .re    (cmd.start),
        .raddr (fdepth_m1[IDW-1:0]),
        .rdata (stack_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_action_reg <= s_tuser;
            req_id_reg     <= s_buf_idx;
            req_len_reg    <= s_used_len;
        end
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_inuse_reg  <= res_inuse;
            out_ref_reg    <= res_ref;
            out_used_reg   <= res_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && cache_we) begin
            cache_reg[rdepth_reg[CIW-1:0]] <= req_id_reg[IDW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdepth_reg    <= COUNT_F;
            rdepth_reg    <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                stat_reg[i] <= '0;
            end
        end else begin
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.commit) begin
                fdepth_reg    <= fdepth_next;
                rdepth_reg    <= rdepth_next;
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NS; i++) begin
                    if (bump[i] && stat_reg[i] != rcbp_pkg::CNT_MAX) begin
                        stat_reg[i] <= stat_reg[i] + 1'b1;
                    end
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_last = (clr_idx_reg == LAST_ID);
    assign sts.out_free   = !out_valid_reg || m_tready;

    // Counters only move on commit, which waits for the result slot to drain,
    // so they can feed the result directly.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {PAD_W'(0),
                       stat_reg[rcbp_pkg::STAT_EXH],
                       stat_reg[rcbp_pkg::STAT_MISS],
                       stat_reg[rcbp_pkg::STAT_HIT],
                       stat_reg[rcbp_pkg::STAT_REL],
                       stat_reg[rcbp_pkg::STAT_ACQ],
                       out_used_reg, out_ref_reg, out_inuse_reg, out_id_reg};

`ifndef SYNTHESIS
    a_cache_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rdepth_reg <= CACHE_C)
        else $error("recent cache depth beyond its size");

    a_ids_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, fdepth_reg} + (FDW + 1)'(rdepth_reg)) <= (FDW + 1)'(BUFFER_COUNT))
        else $error("more free ids than buffers");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_no_start_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !cmd.clear)
        else $error("request accepted during init sweep");
`endif

endmodule

>>> src/refcounted_buffer_pool.sv
// Top level of the reference-counted packet buffer pool.
// Ties the sequencer to the datapath. Depends on rcbp_pkg, rcbp_ctrl, rcbp_datapath.
//
// Usage:
//   Slave channel (s_): one request per transfer. s_tuser carries the action
//   (acquire, release, add reference, set used, reset used, query); s_tdata
//   carries the buffer index and used_len. Master channel (m_): one result per
//   request. m_tuser carries status; m_tdata carries the addressed or
//   acquired id, its alloc flag, reference count and used length, and the
//   five saturating statistics counters.
//   Timing: a request is accepted in S_IDLE; its result is loaded into the
//   output register by the commit in S_EXEC, after the registered RAM read,
//   and the pool takes no new request until that read-modify-write commit
//   is done.
//   Reset: aresetn (synchronous, active low) starts an init sweep over all
//   BUFFER_COUNT entries that zeroes the metadata RAM and loads the free
//   stack; s_tready stays low until it finishes.
//   Back-pressure: a new request is accepted while a result still waits on
//   m_; the commit of that request holds until the waiting result is taken.
module refcounted_buffer_pool #(
    parameter int BUFFER_COUNT = rcbp_pkg::DEF_BUFFER_COUNT,
    parameter int BUFFER_BYTES = rcbp_pkg::DEF_BUFFER_BYTES,
    parameter int CACHE_DEPTH  = rcbp_pkg::DEF_CACHE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] buffer index, [39:16] used_len
    input  logic [rcbp_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] action
    input  logic [rcbp_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] result_id, [16] in_use, [24:17] reference count, [41:25] used_bytes,
    // [73:42] acquire_total, [105:74] release_total, [137:106] hit_total,
    // [169:138] miss_total, [201:170] exhaust_total, [207:202] zero
    output logic [rcbp_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [rcbp_pkg::STATUS_W-1:0]  m_tuser
);

    rcbp_pkg::cmd_t cmd;
    rcbp_pkg::sts_t sts;

    // Sequencer: sweep, accept, commit
    rcbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Storage, update logic and result register
    rcbp_datapath #(
        .BUFFER_COUNT (BUFFER_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES),
        .CACHE_DEPTH  (CACHE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for refcounted_buffer_pool: a scoreboard class predicts
// every result from its own copy of the pool state, and plain tasks drive the streams.
// Depends on rcbp_pkg and the refcounted_buffer_pool RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcbp_pkg::*;

    localparam int POOL_SIZE   = DEF_BUFFER_COUNT;
    localparam int POOL_BYTES  = DEF_BUFFER_BYTES;
    localparam int CACHE_SLOTS = DEF_CACHE_DEPTH;
    localparam int RANDOM_REQS = 468;
    localparam int SAT_BURST   = 258;
    localparam int MAX_REPORTS = 10;

    // Spare request codes; the pool treats them as query
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic [5:0]        pad;
        logic [STAT_W-1:0] exhaust_total;
        logic [STAT_W-1:0] miss_total;
        logic [STAT_W-1:0] hit_total;
        logic [STAT_W-1:0] release_total;
        logic [STAT_W-1:0] acquire_total;
        logic [USED_W-1:0] used_bytes;
        logic [REF_W-1:0]  refs;
        logic              in_use;
        logic [ID_W-1:0]   result_id;
    } pool_word_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        pool_word_t          word;
    } pool_result_t;

    // Shadow of the pool plus the queue of results still owed by the block
    class pool_scoreboard;
        bit                alloc_flag[POOL_SIZE];
        bit [REF_W-1:0]    ref_cnt[POOL_SIZE];
        bit [USED_W-1:0]   used_len[POOL_SIZE];
        bit [ID_W-1:0]     free_ids[POOL_SIZE];
        int                free_top;
        bit [ID_W-1:0]     recent_ids[CACHE_SLOTS];
        int                recent_top;
        bit [STAT_W-1:0]   stats[NUM_STAT];
        pool_result_t      owed_results[$];
        int                mismatches;

        function new();
            for (int i = 0; i < POOL_SIZE; i++) begin
                alloc_flag[i] = 0;
                ref_cnt[i]    = '0;
                used_len[i]   = '0;
                free_ids[i]   = ID_W'(POOL_SIZE - 1 - i);
            end
            free_top   = POOL_SIZE;
            recent_top = 0;
            for (int i = 0; i < NUM_STAT; i++) stats[i] = '0;
            mismatches = 0;
        endfunction

        function void bump(int slot);
            if (stats[slot] != CNT_MAX) stats[slot]++;
        endfunction

        function pool_result_t make_result(logic [STATUS_W-1:0] status,
                                           logic [ID_W-1:0] id, bit addressed);
            pool_result_t r;
            int b;
            b = int'(id) % POOL_SIZE;
            r.status             = status;
            r.word               = '0;
            r.word.result_id     = id;
            r.word.in_use        = addressed ? alloc_flag[b] : 1'b0;
            r.word.refs          = addressed ? ref_cnt[b] : '0;
            r.word.used_bytes    = addressed ? used_len[b] : '0;
            r.word.acquire_total = stats[STAT_ACQ];
            r.word.release_total = stats[STAT_REL];
            r.word.hit_total     = stats[STAT_HIT];
            r.word.miss_total    = stats[STAT_MISS];
            r.word.exhaust_total = stats[STAT_EXH];
            return r;
        endfunction

        // Apply one accepted request to the shadow and queue its result
        function void note_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                   logic [LEN_W-1:0] len);
            bit          got;
            bit [ID_W-1:0] pick;
            int          b;
            got  = 0;
            pick = '0;
            if (act == ACT_ACQUIRE) begin
                if (recent_top > 0) begin
                    recent_top--;
                    pick = recent_ids[recent_top];
                    got  = 1;
                    bump(STAT_HIT);
                end else begin
                    // a miss counts even when the stack is dry too
                    bump(STAT_MISS);
                    if (free_top > 0) begin
                        free_top--;
                        pick = free_ids[free_top];
                        got  = 1;
                    end
                end
                if (got) begin
                    alloc_flag[pick] = 1;
                    ref_cnt[pick]    = 1;
                    used_len[pick]   = '0;
                    bump(STAT_ACQ);
                    owed_results.push_back(make_result(ST_OK, pick, 1));
                end else begin
                    bump(STAT_EXH);
                    owed_results.push_back(make_result(ST_EXHAUSTED, '0, 0));
                end
                return;
            end
            if (int'(id) >= POOL_SIZE) begin
                owed_results.push_back(make_result(ST_BAD_ID, id, 0));
                return;
            end
            b = int'(id);
            case (act)
                ACT_RELEASE: begin
                    // a release of a free buffer leaves the free lists alone
                    if (alloc_flag[b]) begin
                        if (ref_cnt[b] > 0) ref_cnt[b]--;
                        if (ref_cnt[b] == 0) begin
                            alloc_flag[b] = 0;
                            used_len[b]   = '0;
                            bump(STAT_REL);
                            if (recent_top < CACHE_SLOTS) begin
                                recent_ids[recent_top] = id;
                                recent_top++;
                            end else if (free_top < POOL_SIZE) begin
                                free_ids[free_top] = id;
                                free_top++;
                            end
                        end
                    end
                end
                ACT_ADD_REF: begin
                    if (ref_cnt[b] < REF_MAX) ref_cnt[b]++;
                end
                ACT_SET_USED: begin
                    used_len[b] = (int'(len) > POOL_BYTES) ? USED_W'(POOL_BYTES)
                                                           : USED_W'(len);
                end
                ACT_RESET_USED: begin
                    used_len[b] = '0;
                end
                default: begin
                end
            endcase
            owed_results.push_back(make_result(ST_OK, id, 1));
        endfunction

        function void compare_field(string name, logic [STAT_W-1:0] want,
                                    logic [STAT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, got %0h",
                             $realtime, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] data);
            pool_result_t want;
            pool_word_t   got;
            got = pool_word_t'(data);
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no request waiting, status %0h id %0h",
                             $realtime, status, got.result_id);
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", STAT_W'(want.status), STAT_W'(status));
            compare_field("result_id", STAT_W'(want.word.result_id), STAT_W'(got.result_id));
            compare_field("in_use", STAT_W'(want.word.in_use), STAT_W'(got.in_use));
            compare_field("refs", STAT_W'(want.word.refs), STAT_W'(got.refs));
            compare_field("used_bytes", STAT_W'(want.word.used_bytes),
                          STAT_W'(got.used_bytes));
            compare_field("acquire_total", want.word.acquire_total, got.acquire_total);
            compare_field("release_total", want.word.release_total, got.release_total);
            compare_field("hit_total", want.word.hit_total, got.hit_total);
            compare_field("miss_total", want.word.miss_total, got.miss_total);
            compare_field("exhaust_total", want.word.exhaust_total, got.exhaust_total);
        endfunction

        function int allocated_count();
            int n;
            n = 0;
            for (int i = 0; i < POOL_SIZE; i++) n += alloc_flag[i];
            return n;
        endfunction

        // Pick a random allocated id, or any valid id when none is allocated
        function logic [ID_W-1:0] pick_allocated();
            logic [ID_W-1:0] held[$];
            for (int i = 0; i < POOL_SIZE; i++)
                if (alloc_flag[i]) held.push_back(ID_W'(i));
            if (held.size() == 0) return ID_W'($urandom_range(0, POOL_SIZE - 1));
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        function logic [ID_W-1:0] pick_free();
            logic [ID_W-1:0] idle_ids[$];
            for (int i = 0; i < POOL_SIZE; i++)
                if (!alloc_flag[i]) idle_ids.push_back(ID_W'(i));
            if (idle_ids.size() == 0) return ID_W'($urandom_range(0, POOL_SIZE - 1));
            return idle_ids[$urandom_range(0, idle_ids.size() - 1)];
        endfunction

        function bit pool_dry();
            return (free_top == 0) && (recent_top == 0);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    pool_scoreboard pool_sb = new();

    // Idle stretches: each side draws runs, each one either with or without random gaps
    int s_run_left = 0;
    bit s_run_quiet = 0;
    int m_run_left = 0;
    bit m_run_quiet = 0;

    // Random traffic alternates between filling the pool and draining it
    bit filling = 1;
    int dry_acquires = 0;

    refcounted_buffer_pool dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_idle(inout int run_left, inout bit run_quiet);
        if (run_left == 0) begin
            run_left  = $urandom_range(1, 40);
            run_quiet = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // Present one request and hold it until the pool takes it; valid stays
    // high across back-to-back requests so it never toggles within a step.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                logic [LEN_W-1:0] len);
        int gap;
        gap = draw_idle(s_run_left, s_run_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {len, id};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pool_sb.note_request(act, id, len);
    endtask

    function automatic logic [LEN_W-1:0] random_len();
        case ($urandom_range(0, 3))
            0: return LEN_W'($urandom);
            1: return LEN_W'(POOL_BYTES - 2 + $urandom_range(0, 4));
            2: return LEN_W'($urandom_range(0, 1600));
            default: return '1;
        endcase
    endfunction

    // Draw one random request; well-formed traffic on held buffers dominates
    task automatic random_request();
        int              roll;
        logic [ACTION_W-1:0] act;
        logic [ID_W-1:0] id;
        logic [LEN_W-1:0] len;
        roll = $urandom_range(0, 99);
        len  = random_len();
        id   = pool_sb.pick_allocated();
        if (filling) begin
            if (roll < 75) begin
                act = ACT_ACQUIRE;
                id  = ID_W'($urandom);
            end else if (roll < 80) act = ACT_RELEASE;
            else if (roll < 84) act = ACT_ADD_REF;
            else if (roll < 90) act = ACT_SET_USED;
            else if (roll < 92) act = ACT_RESET_USED;
            else if (roll < 95) act = ACT_QUERY;
            else begin
                act = ACTION_W'($urandom_range(0, 7));
                id  = ID_W'($urandom);
            end
        end else begin
            if (roll < 55) act = ACT_RELEASE;
            else if (roll < 60) begin
                // release a buffer that may already be free
                act = ACT_RELEASE;
                id  = ID_W'($urandom_range(0, POOL_SIZE - 1));
            end else if (roll < 65) act = ACT_ADD_REF;
            else if (roll < 75) act = ACT_SET_USED;
            else if (roll < 80) act = ACT_RESET_USED;
            else if (roll < 88) act = ACT_QUERY;
            else if (roll < 93) act = ACT_ACQUIRE;
            else begin
                act = ACTION_W'($urandom_range(0, 7));
                id  = ID_W'($urandom);
            end
        end
        send_request(act, id, len);
        // Switch to draining once the pool has run dry a few times
        if (filling && act == ACT_ACQUIRE && pool_sb.pool_dry()) dry_acquires++;
        if (filling && dry_acquires >= 6) filling = 0;
        if (!filling && pool_sb.allocated_count() <= 2) begin
            filling      = 1;
            dry_acquires = 0;
        end
    endtask

    // Result side: stall at random, take each result and check it
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_idle(m_run_left, m_run_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            pool_sb.check_result(m_tuser, m_tdata);
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #500_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        logic [ID_W-1:0] sat_id;
        int              fails;
        // Hold reset, then release it; the init sweep then runs with s_tready low
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every request code, each special case
        send_request(ACT_QUERY, '0, '0);                  // free buffer
        send_request(ACT_ACQUIRE, '1, '1);                // first id off the stack
        send_request(ACT_ADD_REF, 16'd0, '0);
        send_request(ACT_SET_USED, 16'd0, '1);            // clamp to buffer size
        send_request(ACT_SET_USED, 16'd0, LEN_W'(POOL_BYTES));
        send_request(ACT_SET_USED, 16'd0, LEN_W'(POOL_BYTES - 1));
        send_request(ACT_RESET_USED, 16'd0, '1);
        send_request(ACT_RELEASE, 16'd0, '0);             // two refs down to one
        send_request(ACT_RELEASE, 16'd0, '0);             // freed into the cache
        send_request(ACT_RELEASE, 16'd0, '0);             // release of a free buffer
        send_request(ACT_ADD_REF, 16'd0, '0);             // add reference while free
        send_request(ACT_ACQUIRE, '0, '0);                // cache hit
        send_request(ACT_ACQUIRE, '0, '0);                // cache miss
        send_request(ACT_SET_USED, 16'd1, '0);
        send_request(ACT_QUERY, ID_W'(POOL_SIZE - 1), '0);
        send_request(ACT_RELEASE, ID_W'(POOL_SIZE), '0);  // invalid ids, each code
        send_request(ACT_ADD_REF, '1, '0);
        send_request(ACT_SET_USED, '1, '1);
        send_request(ACT_RESET_USED, ID_W'(POOL_SIZE), '0);
        send_request(ACT_QUERY, '1, '0);
        send_request(ACT_SPARE_LO, 16'd1, '1);            // spare codes act as query
        send_request(ACT_SPARE_HI, '1, '0);
        send_request(ACT_RELEASE, 16'd1, '0);
        send_request(ACT_RELEASE, 16'd0, '0);

        // Drive one free buffer's count into saturation
        sat_id = pool_sb.pick_free();
        repeat (SAT_BURST) send_request(ACT_ADD_REF, sat_id, random_len());

        repeat (RANDOM_REQS) random_request();

        @(posedge aclk);
        s_tvalid <= 1'b0;

        // Drain every owed result, then idle past the pipeline latency
        while (pool_sb.owed_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        fails = pool_sb.mismatches + pool_sb.owed_results.size();
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
